FILE: rtl/itae_pkg.sv
// itae_pkg: constants, atan table and shared types for the tilt estimator
// used by itae_cordic and imu_tilt_angle_estimator
`timescale 1ns / 1ps

package itae_pkg;

  localparam int unsigned CORDIC_ITERS = 16;
  localparam int unsigned ITER_W = 4;
  localparam logic [15:0] PERIOD_RESET = 16'd655;
  localparam logic [8:0] WEIGHT_RESET = 9'd0;
  localparam logic signed [15:0] DEG90_Q7 = 16'sd11520;
  localparam logic [23:0] DEG90_Q16 = 24'd5898240;

  localparam logic CFG_SAMPLE_PERIOD = 1'b0;
  localparam logic CFG_GYRO_WEIGHT = 1'b1;

  // atan(2^-i) in degrees, Q.16
  function automatic logic [21:0] atan_lut(input logic [ITER_W-1:0] i);
    logic [21:0] v;
    begin
      unique case (i)
        4'd0: v = 22'd2949120;
        4'd1: v = 22'd1740967;
        4'd2: v = 22'd919879;
        4'd3: v = 22'd466945;
        4'd4: v = 22'd234379;
        4'd5: v = 22'd117304;
        4'd6: v = 22'd58666;
        4'd7: v = 22'd29335;
        4'd8: v = 22'd14668;
        4'd9: v = 22'd7334;
        4'd10: v = 22'd3667;
        4'd11: v = 22'd1833;
        4'd12: v = 22'd917;
        4'd13: v = 22'd458;
        4'd14: v = 22'd229;
        default: v = 22'd115;
      endcase
      return v;
    end
  endfunction

  // control between top level and the cordic unit
  typedef struct packed {
    logic start;
    logic done;
  } cordic_ctl_t;

endpackage

FILE: rtl/imu_tilt_angle_estimator.sv
// imu_tilt_angle_estimator: accelerometer tilt with gyro complementary filter
// depends on itae_pkg and itae_cordic
`timescale 1ns / 1ps
//
// channel | direction | handshake      | payload
// in      | input     | valid / stall  | accel_x/y/z, rate_x/y
// out     | output    | valid / stall  | roll_angle, pitch_angle, undefined_tilt
// cfg     | input     | valid / ready  | addr (0 period, 1 weight), data
//
// a word runs through serial integrate, square root (24 steps of 2 bits), two
// cordic passes on one shared unit, serial blend and the load of the output
// register. a pass that a special case settles does not start the cordic.
// the output register frees the input side; the next word is taken once the
// previous result is loaded into it. reset is synchronous, active low, and
// clears control state, the integrators and the config registers to their defaults.

module imu_tilt_angle_estimator
  import itae_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_accel_x,
  input  logic [15:0] in_accel_y,
  input  logic [15:0] in_accel_z,
  input  logic [15:0] in_rate_x,
  input  logic [15:0] in_rate_y,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_roll_angle,
  output logic [15:0] out_pitch_angle,
  output logic        out_undefined_tilt,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_addr,
  input  logic [15:0] cfg_data
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_INTEG = 7'b0000010,
    S_SQRT  = 7'b0000100,
    S_ROLL  = 7'b0001000,
    S_PITCH = 7'b0010000,
    S_BLEND = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic [15:0] period_r;
  logic [8:0] weight_r;
  logic signed [39:0] roll_int_r, pitch_int_r;
  logic signed [15:0] last_rx_r, last_ry_r;
  logic signed [15:0] ax_r, ay_r, az_r, rx_r, ry_r;
  logic [5:0] cnt_r;
  logic signed [15:0] roll_acc_r, pitch_acc_r;
  logic out_valid_r;
  logic [15:0] out_roll_r, out_pitch_r;
  logic out_flag_r;

  logic in_acc, out_free;
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != S_IDLE);
  assign in_acc = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= PERIOD_RESET; weight_r <= WEIGHT_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_addr)
        CFG_SAMPLE_PERIOD: period_r <= cfg_data;
        CFG_GYRO_WEIGHT: weight_r <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  // magnitudes
  logic [15:0] aax, aay, aaz;
  assign aax = ax_r[15] ? 16'(-ax_r) : ax_r;
  assign aay = ay_r[15] ? 16'(-ay_r) : ay_r;
  assign aaz = az_r[15] ? 16'(-az_r) : az_r;

  // bit-serial integration: shift-add of rate sum by period bits
  logic signed [16:0] rsx_r, rsy_r;
  logic [15:0] psh_r;
  logic signed [33:0] prx_r, pry_r;
  logic signed [39:0] sum_x, sum_y;
  logic signed [40:0] accx, accy;
  logic signed [28:0] incx, incy;
  assign incx = 29'((prx_r + 34'sd16) >>> 5);
  assign incy = 29'((pry_r + 34'sd16) >>> 5);
  assign accx = 41'(roll_int_r) + 41'(incx);
  assign accy = 41'(pitch_int_r) + 41'(incy);

  function automatic logic signed [39:0] sat40(input logic signed [40:0] v);
    begin
      if (v[40] != v[39]) return v[40] ? {1'b1, 39'd0} : {1'b0, {39{1'b1}}};
      return v[39:0];
    end
  endfunction
  assign sum_x = sat40(accx);
  assign sum_y = sat40(accy);

  // bit-serial square root of (ay^2 + az^2) << 16, 2 bits per cycle
  logic [47:0] sq_rad_r;
  logic [25:0] sq_root_r;
  logic [27:0] sq_rem_r;
  logic [27:0] sq_trial;
  logic [27:0] sq_rem_sh;
  assign sq_rem_sh = {sq_rem_r[25:0], sq_rad_r[47:46]};
  assign sq_trial = sq_rem_sh - {sq_root_r[25:0], 2'b01};
  logic [31:0] sumsq;
  assign sumsq = 32'(aay) * 32'(aay) + 32'(aaz) * 32'(aaz);

  // shared cordic
  logic c_start;
  logic [39:0] c_y, c_x;
  cordic_ctl_t c_ctl;
  logic [15:0] c_angle;
  itae_cordic u_cordic (
    .clk(clk), .rst_n(rst_n), .start(c_start), .y_in(c_y), .x_in(c_x),
    .ctl(c_ctl), .angle(c_angle)
  );

  logic roll_flag, roll_ok, pitch_ok;
  assign roll_flag = (ay_r == 0) && (az_r == 0);
  assign roll_ok = !roll_flag && (ay_r != 0) && (az_r != 0);
  assign pitch_ok = (ax_r != 0) && (sq_root_r != 0);
  logic roll_neg;
  assign roll_neg = (ay_r[15] != az_r[15] && az_r != 0) || (az_r == 0 && ay_r[15]);

  logic c_busy_r;

  // blend: serial multiply of gyro Q16 by w, accel by (256-w)
  logic [8:0] w_sat, wsh_r, wish_r;
  assign w_sat = (weight_r > 9'd256) ? 9'd256 : weight_r;
  logic signed [49:0] br_r, bp_r;
  logic signed [49:0] rr, rp;
  assign rr = (br_r + 50'sd65536) >>> 17;
  assign rp = (bp_r + 50'sd65536) >>> 17;
  function automatic logic [15:0] sat16(input logic signed [49:0] v);
    begin
      if (v > 50'sd32767) return 16'h7fff;
      if (v < -50'sd32768) return 16'h8000;
      return v[15:0];
    end
  endfunction

  always_comb begin
    c_start = 1'b0; c_y = '0; c_x = '0;
    if (state_r == S_SQRT && cnt_r == 6'd24) begin
      c_start = roll_ok;
      c_y = {16'd0, aay, 8'd0}; c_x = {16'd0, aaz, 8'd0};
    end else if (state_r == S_ROLL && (c_ctl.done || !c_busy_r)) begin
      c_start = pitch_ok;
      c_y = {16'd0, aax, 8'd0}; c_x = {14'd0, sq_root_r};
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_acc) state_nxt = S_INTEG;
      S_INTEG: if (cnt_r == 6'd15) state_nxt = S_SQRT;
      S_SQRT: if (cnt_r == 6'd24) state_nxt = S_ROLL;
      S_ROLL: if (c_ctl.done || !c_busy_r) state_nxt = S_PITCH;
      S_PITCH: if (c_ctl.done || !c_busy_r) state_nxt = S_BLEND;
      S_BLEND: if (cnt_r == 6'd8) state_nxt = S_OUT;
      S_OUT: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; cnt_r <= '0; c_busy_r <= 1'b0; out_valid_r <= 1'b0;
      roll_int_r <= '0; pitch_int_r <= '0; last_rx_r <= '0; last_ry_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_nxt != state_r) cnt_r <= '0;
      else cnt_r <= cnt_r + 1'b1;
      if (c_start) c_busy_r <= 1'b1;
      else if (c_ctl.done) c_busy_r <= 1'b0;
      // output valid: load beats release
      if (state_r == S_OUT && out_free) out_valid_r <= 1'b1;
      else if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      // load the captured word
      if (in_acc) begin
        ax_r <= in_accel_x; ay_r <= in_accel_y; az_r <= in_accel_z;
        rx_r <= in_rate_x; ry_r <= in_rate_y;
        rsx_r <= 17'(signed'(in_rate_x)) + 17'(last_rx_r);
        rsy_r <= 17'(signed'(in_rate_y)) + 17'(last_ry_r);
        psh_r <= period_r; prx_r <= '0; pry_r <= '0;
      end
      // period bits msb first
      if (state_r == S_INTEG) begin
        prx_r <= (prx_r <<< 1) + (psh_r[15] ? 34'(rsx_r) : 34'sd0);
        pry_r <= (pry_r <<< 1) + (psh_r[15] ? 34'(rsy_r) : 34'sd0);
        psh_r <= psh_r << 1;
        if (cnt_r == 6'd15) begin
          last_rx_r <= rx_r; last_ry_r <= ry_r;
          sq_rad_r <= {sumsq, 16'd0}; sq_root_r <= '0; sq_rem_r <= '0;
        end
      end
      if (state_r == S_SQRT && cnt_r == 6'd0) begin
        roll_int_r <= sum_x; pitch_int_r <= sum_y;
      end
      if (state_r == S_SQRT && cnt_r != 6'd24) begin
        sq_rad_r <= sq_rad_r << 2;
        if (!sq_trial[27]) begin
          sq_rem_r <= sq_trial; sq_root_r <= {sq_root_r[24:0], 1'b1};
        end else begin
          sq_rem_r <= sq_rem_sh; sq_root_r <= {sq_root_r[24:0], 1'b0};
        end
      end
      if (state_r == S_SQRT && cnt_r == 6'd24) begin
        if (roll_flag || ay_r == 0) roll_acc_r <= '0;
        else roll_acc_r <= roll_neg ? -DEG90_Q7 : DEG90_Q7;
      end
      if (state_r == S_ROLL && c_ctl.done)
        roll_acc_r <= roll_neg ? 16'(-c_angle) : c_angle;
      if (state_r == S_ROLL && state_nxt == S_PITCH) begin
        if (ax_r == 0) pitch_acc_r <= '0;
        else pitch_acc_r <= ax_r[15] ? -DEG90_Q7 : DEG90_Q7;
      end
      if (state_r == S_PITCH && c_ctl.done)
        pitch_acc_r <= ax_r[15] ? 16'(-c_angle) : c_angle;
      // serial blend over 9 weight bits, msb first
      if (state_r == S_PITCH && state_nxt == S_BLEND) begin
        br_r <= '0; bp_r <= '0; wsh_r <= w_sat; wish_r <= 9'd256 - w_sat;
      end
      if (state_r == S_BLEND) begin
        br_r <= (br_r <<< 1) + (wsh_r[8] ? 50'(roll_int_r) : 50'sd0)
              + (wish_r[8] ? 50'(roll_acc_r) * 50'sd512 : 50'sd0);
        bp_r <= (bp_r <<< 1) + (wsh_r[8] ? 50'(pitch_int_r) : 50'sd0)
              + (wish_r[8] ? 50'(pitch_acc_r) * 50'sd512 : 50'sd0);
        wsh_r <= wsh_r << 1; wish_r <= wish_r << 1;
      end
      if (state_r == S_OUT && out_free) begin
        out_roll_r <= sat16(rr); out_pitch_r <= sat16(rp);
        out_flag_r <= roll_flag;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_roll_angle = out_roll_r;
  assign out_pitch_angle = out_pitch_r;
  assign out_undefined_tilt = out_flag_r;

  // checks
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> in_stall) else $error("accept while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> $stable(out_roll_angle)) else $error("out changed");
  a_cordic_start: assert property (@(posedge clk) disable iff (!rst_n)
    c_start |-> !c_busy_r || c_ctl.done) else $error("cordic restart");

endmodule

FILE: rtl/itae_cordic.sv
// itae_cordic: iterative vectoring cordic, atan(y/x) in Q9.7 degrees, y,x >= 0
// depends on itae_pkg
`timescale 1ns / 1ps

module itae_cordic
  import itae_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [39:0]        y_in,
  input  logic [39:0]        x_in,
  output cordic_ctl_t        ctl,
  output logic [15:0]        angle
);

  logic signed [41:0] x_r, x_nxt, y_r, y_nxt;
  logic signed [25:0] z_r, z_nxt;
  logic [ITER_W-1:0] it_r, it_nxt;
  logic busy_r, busy_nxt, done_r, done_nxt;
  logic signed [41:0] dx, dy;
  logic [23:0] zc;
  logic [24:0] zr;

  assign dx = y_r >>> it_r;
  assign dy = x_r >>> it_r;

  // one micro-rotation per cycle
  always_comb begin
    x_nxt = x_r; y_nxt = y_r; z_nxt = z_r;
    it_nxt = it_r; busy_nxt = busy_r; done_nxt = 1'b0;
    if (start) begin
      x_nxt = $signed({2'b00, x_in});
      y_nxt = $signed({2'b00, y_in});
      z_nxt = '0; it_nxt = '0; busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!y_r[41]) begin
        x_nxt = x_r + dx; y_nxt = y_r - dy;
        z_nxt = z_r + $signed({4'd0, atan_lut(it_r)});
      end else begin
        x_nxt = x_r - dx; y_nxt = y_r + dy;
        z_nxt = z_r - $signed({4'd0, atan_lut(it_r)});
      end
      it_nxt = it_r + 1'b1;
      if (it_r == ITER_W'(CORDIC_ITERS - 1)) begin
        busy_nxt = 1'b0; done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0; it_r <= '0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt; it_r <= it_nxt;
    end
    x_r <= x_nxt; y_r <= y_nxt; z_r <= z_nxt;
  end

  // clamp to [0, 90] and round to Q.7
  always_comb begin
    if (z_r < 0) zc = '0;
    else if (z_r > $signed({2'b00, DEG90_Q16})) zc = DEG90_Q16;
    else zc = z_r[23:0];
    zr = {1'b0, zc} + 25'd256;
  end

  assign angle = zr[24:9];
  assign ctl.start = start;
  assign ctl.done = done_r;

endmodule
